// ----- rtl/core/drq_pkg.sv -----
package drq_pkg;

  // Field widths
  localparam int DIST_W    = 8;
  localparam int NEAR_W    = 12;
  localparam int FAR_W     = 15;
  localparam int FAULT_W   = 4;
  localparam int SETTLE_W  = 7;
  localparam int TARGET_W  = 5;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // Quotient and dividend width of the step divider
  localparam int DIV_W     = 15;
  localparam int DIV_CNT_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIVISOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_TARGET   = 3'd4;

  // Register reset values
  localparam logic [NEAR_W-1:0]   NEAR_RST   = 12'd181;
  localparam logic [FAR_W-1:0]    FAR_RST    = 15'd1804;
  localparam logic [FAULT_W-1:0]  FAULT_RST  = 4'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 7'd100;
  localparam logic [TARGET_W-1:0] TARGET_RST = 5'd20;

  // Fixed values
  localparam logic [DIST_W-1:0]   LEVEL_FORCED = 8'd255;
  localparam logic [DIST_W-1:0]   LEVEL_ZERO   = 8'd0;
  localparam logic [DIST_W-1:0]   PING_IDLE    = 8'd3;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX   = 7'd127;
  localparam logic [FAULT_W-1:0]  FAIL_MAX     = 4'd15;

  // Calibration status codes
  localparam logic [STATUS_W-1:0] CALIB_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] CALIB_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] CALIB_BUSY = 2'd2;

endpackage

// ----- rtl/core/drq_in_if.sv -----
interface drq_in_if
  import drq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              reading_ok;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output reading_ok, output distance, input ready);
  modport sink   (input valid, input reading_ok, input distance, output ready);
endinterface

// ----- rtl/core/drq_out_if.sv -----
interface drq_out_if
  import drq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   level;
  logic                level_valid;
  logic                fault_active;
  logic [STATUS_W-1:0] calib_status;

  modport source (output valid, output level, output level_valid, output fault_active,
                  output calib_status, input ready);
  modport sink   (input valid, input level, input level_valid, input fault_active,
                  input calib_status, output ready);
endinterface

// ----- rtl/core/drq_cfg_if.sv -----
interface drq_cfg_if
  import drq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/core/drq_div.sv -----
module drq_div
  import drq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     rem_r,  rem_nxt;
  logic [DIV_W-1:0]     quo_r,  quo_nxt;
  logic [DIV_W-1:0]     dvs_r,  dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_W:0]       trial;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/distance_reading_qualifier_core.sv -----
// Distance reading qualifier: filters one sensor poll per request.
// in_ch carries a poll (reading_ok, distance); out_ch returns one result per
// poll (level, level_valid, fault_active, calib_status), in poll order.
// cfg_ch writes the five configuration registers by index; it is always
// ready, and writes to unused indexes are dropped. Write it only while idle.
// A good poll is accepted, the bit-serial restoring divider forms the
// filter step, the quotient is handed back and the update state registers
// the result. A failed poll skips the divider and goes straight to the
// update state. Polls are taken one at a time: a new poll is accepted only
// after the previous one has left the update state and returned to idle.
// The output register decouples the two sides: a new poll is accepted while
// the previous result still waits. If the receiver stalls, the finished poll
// waits in the update stage and no further poll is accepted until the
// result register frees up.
// Reset (synchronous, rst_n low) restores register defaults, clears the held
// value, counters and flags, sets the last ping to 3 and empties the output.
module distance_reading_qualifier_core
  import drq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  drq_in_if.sink       in_ch,
  drq_out_if.source    out_ch,
  drq_cfg_if.sink      cfg_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [NEAR_W-1:0]   near_r,   near_nxt;
  logic [FAR_W-1:0]    far_r,    far_nxt;
  logic [FAULT_W-1:0]  flimit_r, flimit_nxt;
  logic [SETTLE_W-1:0] settle_lim_r, settle_lim_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;

  // Filter state
  logic [DIST_W-1:0]   held_r,       held_nxt;
  logic [DIST_W-1:0]   shown_r,      shown_nxt;
  logic                good_r,       good_nxt;
  logic [FAULT_W-1:0]  fail_r,       fail_nxt;
  logic [SETTLE_W-1:0] settle_r,     settle_nxt;
  logic [DIST_W-1:0]   last_ping_r,  last_ping_nxt;
  logic [TARGET_W-1:0] ping_cnt_r,   ping_cnt_nxt;

  // Poll in flight
  logic                ok_r,   ok_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [DIST_W-1:0]   d_r,    d_nxt;
  logic                up_r,   up_nxt;
  logic                zero_r, zero_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_level_r, out_level_nxt;
  logic                out_lv_r,    out_lv_nxt;
  logic                out_fault_r, out_fault_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Divider hookup
  logic                div_start;
  logic                div_done;
  logic [DIV_W-1:0]    quo_w;

  // Step operands from the incoming poll
  logic              in_up;
  logic [DIST_W-1:0] in_d;
  logic [DIV_W-1:0]  m_w;
  logic [DIV_W-1:0]  divisor_w;

  assign in_up = in_ch.distance > held_r;
  assign in_d  = in_up ? DIST_W'(in_ch.distance - held_r) : DIST_W'(held_r - in_ch.distance);
  // m = 100*d as 64d + 32d + 4d
  assign m_w   = DIV_W'({in_d, 6'b0}) + DIV_W'({in_d, 5'b0}) + DIV_W'({in_d, 2'b0});
  assign divisor_w = (m_w < far_r) ? DIV_W'(near_r) : far_r;

  drq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (m_w),
    .divisor  (divisor_w),
    .done     (div_done),
    .quotient (quo_w)
  );

  // Held value update from the finished quotient
  logic              snap_w;
  logic [DIST_W-1:0] moved_w;
  logic [DIST_W-1:0] new_held_w;
  logic              ping_ok_w;
  logic [TARGET_W-1:0] pc_inc_w;
  logic [FAULT_W-1:0]  fail_inc_w;
  logic                fault_w;
  logic                out_free;

  assign snap_w     = zero_r || (quo_w == '0) || (quo_w >= DIV_W'(d_r));
  assign moved_w    = up_r ? DIST_W'(held_r + quo_w[DIST_W-1:0])
                           : DIST_W'(held_r - quo_w[DIST_W-1:0]);
  assign new_held_w = snap_w ? dist_r : moved_w;
  assign ping_ok_w  = (last_ping_r >= PING_IDLE) && (new_held_w != LEVEL_FORCED) &&
                      (new_held_w != LEVEL_ZERO);
  assign pc_inc_w   = ping_cnt_r + TARGET_W'(1);
  assign fail_inc_w = (fail_r < FAIL_MAX) ? FAULT_W'(fail_r + FAULT_W'(1)) : fail_r;
  assign fault_w    = fail_inc_w >= flimit_r;
  assign out_free   = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    near_nxt       = near_r;
    far_nxt        = far_r;
    flimit_nxt     = flimit_r;
    settle_lim_nxt = settle_lim_r;
    target_nxt     = target_r;
    held_nxt       = held_r;
    shown_nxt      = shown_r;
    good_nxt       = good_r;
    fail_nxt       = fail_r;
    settle_nxt     = settle_r;
    last_ping_nxt  = last_ping_r;
    ping_cnt_nxt   = ping_cnt_r;
    ok_nxt         = ok_r;
    dist_nxt       = dist_r;
    d_nxt          = d_r;
    up_nxt         = up_r;
    zero_nxt       = zero_r;
    out_valid_nxt  = out_valid_r;
    out_level_nxt  = out_level_r;
    out_lv_nxt     = out_lv_r;
    out_fault_nxt  = out_fault_r;
    out_status_nxt = out_status_r;
    div_start      = 1'b0;

    // Configuration writes
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_NEAR_DIVISOR:   near_nxt       = cfg_ch.wr_data[NEAR_W-1:0];
        REG_FAR_THRESHOLD:  far_nxt        = cfg_ch.wr_data[FAR_W-1:0];
        REG_FAULT_LIMIT:    flimit_nxt     = cfg_ch.wr_data[FAULT_W-1:0];
        REG_SETTLE_SAMPLES: settle_lim_nxt = cfg_ch.wr_data[SETTLE_W-1:0];
        REG_CALIB_TARGET:   target_nxt     = cfg_ch.wr_data[TARGET_W-1:0];
        default: ;
      endcase
    end

    // Result taken by the receiver
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ok_nxt   = in_ch.reading_ok;
          dist_nxt = in_ch.distance;
          d_nxt    = in_d;
          up_nxt   = in_up;
          zero_nxt = (divisor_w == '0);
          if (in_ch.reading_ok) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_fault_nxt  = 1'b0;
          out_status_nxt = CALIB_NONE;
          if (ok_r) begin
            held_nxt  = new_held_w;
            shown_nxt = new_held_w;
            good_nxt  = 1'b1;
            fail_nxt  = '0;
            if (settle_r > settle_lim_r) begin
              // Calibration ping check
              out_status_nxt = CALIB_BUSY;
              if (ping_ok_w) begin
                if (pc_inc_w >= target_r) begin
                  ping_cnt_nxt   = '0;
                  last_ping_nxt  = PING_IDLE;
                  out_status_nxt = CALIB_DONE;
                end else begin
                  ping_cnt_nxt  = pc_inc_w;
                  last_ping_nxt = new_held_w;
                end
              end
            end else if (settle_r < SETTLE_MAX) begin
              settle_nxt = settle_r + SETTLE_W'(1);
            end
            out_level_nxt = new_held_w;
            out_lv_nxt    = 1'b1;
          end else begin
            fail_nxt      = fail_inc_w;
            out_level_nxt = shown_r;
            out_lv_nxt    = good_r;
            if (fault_w) begin
              shown_nxt     = LEVEL_FORCED;
              good_nxt      = 1'b0;
              out_fault_nxt = 1'b1;
              out_level_nxt = LEVEL_FORCED;
              out_lv_nxt    = 1'b0;
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ok_r         <= ok_nxt;
    dist_r       <= dist_nxt;
    d_r          <= d_nxt;
    up_r         <= up_nxt;
    zero_r       <= zero_nxt;
    out_level_r  <= out_level_nxt;
    out_lv_r     <= out_lv_nxt;
    out_fault_r  <= out_fault_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      near_r       <= NEAR_RST;
      far_r        <= FAR_RST;
      flimit_r     <= FAULT_RST;
      settle_lim_r <= SETTLE_RST;
      target_r     <= TARGET_RST;
      held_r       <= '0;
      shown_r      <= '0;
      good_r       <= 1'b0;
      fail_r       <= '0;
      settle_r     <= '0;
      last_ping_r  <= PING_IDLE;
      ping_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      near_r       <= near_nxt;
      far_r        <= far_nxt;
      flimit_r     <= flimit_nxt;
      settle_lim_r <= settle_lim_nxt;
      target_r     <= target_nxt;
      held_r       <= held_nxt;
      shown_r      <= shown_nxt;
      good_r       <= good_nxt;
      fail_r       <= fail_nxt;
      settle_r     <= settle_nxt;
      last_ping_r  <= last_ping_nxt;
      ping_cnt_r   <= ping_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level        = out_level_r;
  assign out_ch.level_valid  = out_lv_r;
  assign out_ch.fault_active = out_fault_r;
  assign out_ch.calib_status = out_status_r;

`ifndef NO_ASSERTIONS
  // A new result only appears from the update stage
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result appeared outside update stage");

  // Held value moves only in the update stage or at reset
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> ($past(state_r == ST_EMIT) || $past(!rst_n)))
    else $error("held value changed outside update stage");

  // A faulted result always shows the forced, invalid level
  a_fault_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_level_r == LEVEL_FORCED && !out_lv_r))
    else $error("fault result without forced level");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide state");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import drq_pkg::*;

  // one poll result as the block reports it
  typedef struct packed {
    logic [DIST_W-1:0]   level;
    logic                level_valid;
    logic                fault_active;
    logic [STATUS_W-1:0] calib_status;
  } level_report_t;

  // directed stimulus row; want is used only when typed is set
  typedef struct {
    logic              ok;
    logic [DIST_W-1:0] rd_dist;
    bit                typed;
    level_report_t     want;
  } poll_row_t;

  localparam level_report_t NO_REPORT = '0;
  localparam int NEAR_TOP       = 4095;
  localparam int FAR_TOP        = 25500;
  localparam int FAULT_TOP      = 15;
  localparam int SETTLE_TOP     = 126;
  localparam int TARGET_TOP     = 31;
  localparam int DIRECTED_ROWS  = 22;
  localparam int SECOND_SET_ROW = 10;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_POLLS    = 153;
  localparam int STEADY_PHASE   = 3;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int STALL_LIMIT    = 2000;
  localparam int IDLE_PCT       = 26;

  logic clk;
  logic rst_n;

  drq_in_if  in_if();
  drq_out_if out_if();
  drq_cfg_if cfg_if();

  distance_reading_qualifier_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow configuration
  logic [NEAR_W-1:0]   cfg_near;
  logic [FAR_W-1:0]    cfg_far;
  logic [FAULT_W-1:0]  cfg_fault_lim;
  logic [SETTLE_W-1:0] cfg_settle;
  logic [TARGET_W-1:0] cfg_target;

  // shadow filter state
  logic [DIST_W-1:0]   held_lvl;
  logic [DIST_W-1:0]   shown_lvl;
  logic                lvl_good;
  logic [FAULT_W-1:0]  fail_run;
  logic [SETTLE_W-1:0] settle_cnt;
  logic [DIST_W-1:0]   last_ping;
  logic [TARGET_W-1:0] ping_cnt;

  level_report_t level_q[$];

  bit steady_mode;
  int polls_sent;
  int results_seen;
  int faults_seen;
  int calib_done_seen;
  int mismatches;

  // directed polls: first set snaps (near 1, far at top, fault 2, settle 0, target 1),
  // second set filters with default divisors and the other extremes
  poll_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, 8'd0,   1'b1, '{8'd0,   1'b0, 1'b0, CALIB_NONE}},
    '{1'b0, 8'd255, 1'b1, '{8'd255, 1'b0, 1'b1, CALIB_NONE}},
    '{1'b1, 8'd128, 1'b1, '{8'd128, 1'b1, 1'b0, CALIB_NONE}},
    '{1'b1, 8'd127, 1'b1, '{8'd127, 1'b1, 1'b0, CALIB_DONE}},
    '{1'b1, 8'd0,   1'b1, '{8'd0,   1'b1, 1'b0, CALIB_BUSY}},
    '{1'b1, 8'd255, 1'b0, NO_REPORT},
    '{1'b0, 8'd85,  1'b0, NO_REPORT},
    '{1'b0, 8'd170, 1'b1, '{8'd255, 1'b0, 1'b1, CALIB_NONE}},
    '{1'b0, 8'd1,   1'b1, '{8'd255, 1'b0, 1'b1, CALIB_NONE}},
    '{1'b1, 8'd200, 1'b0, NO_REPORT},
    '{1'b1, 8'd255, 1'b0, NO_REPORT},
    '{1'b1, 8'd0,   1'b0, NO_REPORT},
    '{1'b1, 8'd201, 1'b0, NO_REPORT},
    '{1'b1, 8'd202, 1'b0, NO_REPORT},
    '{1'b0, 8'd64,  1'b0, NO_REPORT},
    '{1'b0, 8'd32,  1'b0, NO_REPORT},
    '{1'b1, 8'd16,  1'b0, NO_REPORT},
    '{1'b1, 8'd8,   1'b0, NO_REPORT},
    '{1'b0, 8'd4,   1'b0, NO_REPORT},
    '{1'b1, 8'd240, 1'b0, NO_REPORT},
    '{1'b1, 8'd250, 1'b0, NO_REPORT},
    '{1'b1, 8'd99,  1'b0, NO_REPORT}
  };

  // filter one poll against the shadow state and return the level it reports
  function automatic level_report_t qualify_poll(input logic ok, input logic [DIST_W-1:0] rd_dist);
    level_report_t rep;
    int diff;
    int scaled;
    int divisor;
    int step;
    rep = '0;
    rep.calib_status = CALIB_NONE;
    if (ok) begin
      diff    = (rd_dist > held_lvl) ? int'(rd_dist) - int'(held_lvl)
                                     : int'(held_lvl) - int'(rd_dist);
      scaled  = diff * 100;
      divisor = (scaled < int'(cfg_far)) ? int'(cfg_near) : int'(cfg_far);
      step    = (divisor == 0) ? 0 : scaled / divisor;
      // zero step or overshoot lands on the reading
      if (divisor == 0 || step == 0 || step >= diff)
        held_lvl = rd_dist;
      else if (rd_dist > held_lvl)
        held_lvl = held_lvl + step[DIST_W-1:0];
      else
        held_lvl = held_lvl - step[DIST_W-1:0];
      shown_lvl = held_lvl;
      if (settle_cnt > cfg_settle) begin
        rep.calib_status = CALIB_BUSY;
        // count a ping only from a clean previous ping and an in-range level
        if (last_ping >= PING_IDLE && shown_lvl != LEVEL_FORCED && shown_lvl != LEVEL_ZERO) begin
          ping_cnt  = ping_cnt + 1'b1;
          last_ping = shown_lvl;
          if (ping_cnt >= cfg_target) begin
            ping_cnt         = '0;
            last_ping        = PING_IDLE;
            rep.calib_status = CALIB_DONE;
          end
        end
      end else if (settle_cnt < SETTLE_MAX) begin
        settle_cnt = settle_cnt + 1'b1;
      end
      lvl_good = 1'b1;
      fail_run = '0;
    end else begin
      if (fail_run < FAIL_MAX)
        fail_run = fail_run + 1'b1;
      if (fail_run >= cfg_fault_lim) begin
        rep.fault_active = 1'b1;
        shown_lvl        = LEVEL_FORCED;
        lvl_good         = 1'b0;
      end
    end
    rep.level       = shown_lvl;
    rep.level_valid = lvl_good;
    return rep;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender idles at random unless in the steady phase; starts and ends at a falling edge
  task automatic send_poll(input logic ok, input logic [DIST_W-1:0] rd_dist,
                           input bit typed, input level_report_t want);
    level_report_t rep;
    if (!steady_mode) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.reading_ok <= ok;
    in_if.distance   <= rd_dist;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    rep = qualify_poll(ok, rd_dist);
    level_q.push_back(typed ? want : rep);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= value[CFG_DAT_W-1:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_NEAR_DIVISOR:   cfg_near      = value[NEAR_W-1:0];
      REG_FAR_THRESHOLD:  cfg_far       = value[FAR_W-1:0];
      REG_FAULT_LIMIT:    cfg_fault_lim = value[FAULT_W-1:0];
      REG_SETTLE_SAMPLES: cfg_settle    = value[SETTLE_W-1:0];
      REG_CALIB_TARGET:   cfg_target    = value[TARGET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_filter(input int near, input int far, input int fault_lim,
                                input int settle, input int target);
    write_reg(REG_NEAR_DIVISOR, near);
    write_reg(REG_FAR_THRESHOLD, far);
    write_reg(REG_FAULT_LIMIT, fault_lim);
    write_reg(REG_SETTLE_SAMPLES, settle);
    write_reg(REG_CALIB_TARGET, target);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every expected level has come back
  task automatic drain_levels();
    in_if.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls except in the steady phase, and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (steady_mode) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    level_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.fault_active) faults_seen++;
      if (out_if.calib_status == CALIB_DONE) calib_done_seen++;
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual level=%0d", $time, out_if.level);
        mismatches++;
      end else begin
        want = level_q.pop_front();
        check_field("level", want.level, out_if.level);
        check_field("level_valid", want.level_valid, out_if.level_valid);
        check_field("fault_active", want.fault_active, out_if.fault_active);
        check_field("calib_status", want.calib_status, out_if.calib_status);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    int quiet;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d levels outstanding",
                 $time, STALL_LIMIT, level_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int ph;
    int k;
    int burst_left;
    int near;
    int far;
    int fault_lim;
    int settle;
    int target;
    logic ok;
    logic [DIST_W-1:0] rd_dist;
    bit full_range;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.reading_ok = 1'b0;
    in_if.distance   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data   = '0;
    steady_mode      = 1'b0;
    polls_sent       = 0;
    results_seen     = 0;
    faults_seen      = 0;
    calib_done_seen  = 0;
    mismatches       = 0;
    burst_left       = 0;

    cfg_near      = NEAR_RST;
    cfg_far       = FAR_RST;
    cfg_fault_lim = FAULT_RST;
    cfg_settle    = SETTLE_RST;
    cfg_target    = TARGET_RST;
    held_lvl      = '0;
    shown_lvl     = '0;
    lvl_good      = 1'b0;
    fail_run      = '0;
    settle_cnt    = '0;
    last_ping     = PING_IDLE;
    ping_cnt      = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    program_filter(1, FAR_TOP, 2, 0, 1);
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (k == SECOND_SET_ROW) begin
        drain_levels();
        program_filter(NEAR_RST, FAR_RST, FAULT_TOP, SETTLE_TOP, TARGET_TOP);
      end
      send_poll(directed_rows[k].ok, directed_rows[k].rd_dist,
                directed_rows[k].typed, directed_rows[k].want);
    end

    // random phases; first two at the extremes, last two over the full distance range
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_levels();
      if (ph == 0) begin
        near = 1; far = 1; fault_lim = 1; settle = 0; target = 1;
      end else if (ph == 1) begin
        near = NEAR_TOP; far = FAR_TOP; fault_lim = FAULT_TOP;
        settle = SETTLE_TOP; target = TARGET_TOP;
      end else begin
        near      = $urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, NEAR_TOP);
        far       = $urandom_range(0, 1) ? $urandom_range(1, 4000) : $urandom_range(1, FAR_TOP);
        fault_lim = $urandom_range(1, FAULT_TOP);
        settle    = $urandom_range(0, 3) == 0 ? $urandom_range(0, SETTLE_TOP)
                                              : $urandom_range(0, 20);
        target    = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, TARGET_TOP);
      end
      program_filter(near, far, fault_lim, settle, target);
      steady_mode = (ph == STEADY_PHASE);
      full_range  = (ph >= RAND_PHASES - 2);
      for (k = 0; k < PHASE_POLLS; k++) begin
        // failed polls come in runs so the fault limit is reached
        if (burst_left == 0 && $urandom_range(0, 99) < 8)
          burst_left = $urandom_range(1, fault_lim + 3);
        if (burst_left > 0) begin
          burst_left--;
          ok = 1'b0;
        end else begin
          ok = ($urandom_range(0, 99) >= 5);
        end
        // low levels stuck in the ping history block calibration, so keep them to the end
        if (full_range && $urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: rd_dist = 8'd0;
            1: rd_dist = 8'd1;
            2: rd_dist = 8'd2;
            default: rd_dist = 8'd255;
          endcase
        end else if (full_range) begin
          rd_dist = $urandom_range(0, 255);
        end else begin
          rd_dist = $urandom_range(3, 254);
        end
        send_poll(ok, rd_dist, 1'b0, NO_REPORT);
      end
    end
    steady_mode = 1'b0;

    drain_levels();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Polls: %0d sent, %0d results checked over %0d settings, %0d mismatches",
             polls_sent, results_seen, RAND_PHASES + 2, mismatches);
    $display("Faults reported: %0d, calibrations completed: %0d",
             faults_seen, calib_done_seen);
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- distance_reading_qualifier_core.f -----
rtl/core/drq_pkg.sv
rtl/core/drq_in_if.sv
rtl/core/drq_out_if.sv
rtl/core/drq_cfg_if.sv
rtl/core/drq_div.sv
rtl/core/distance_reading_qualifier_core.sv
test/tb_top.sv
